FILE: rtl/dhcp_rop_pkg.sv
`default_nettype none

package dhcp_rop_pkg;

    localparam int HEADER_BYTES = 240;

    // parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CODE   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_NOT_SERVER = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE   = 2'd2;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd3;

    // configuration register indexes
    localparam logic REG_EXPECT_ACK = 1'b0;
    localparam logic REG_TXN_ID     = 1'b1;

    // option codes and message types
    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_LEASE  = 8'd51;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_END    = 8'hff;
    localparam logic [7:0] MSG_OFFER  = 8'd2;
    localparam logic [7:0] MSG_ACK    = 8'd5;
    localparam logic [7:0] OP_REPLY   = 8'd2;

    localparam logic [31:0] TXN_ID_RESET = 32'h1234_5678;

    // capture slots
    localparam logic [1:0] SLOT_MASK   = 2'd0;
    localparam logic [1:0] SLOT_ROUTER = 2'd1;
    localparam logic [1:0] SLOT_SERVER = 2'd2;
    localparam logic [1:0] SLOT_LEASE  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        txn_match;
        logic [31:0] txn_id;
        logic [31:0] client_addr;
        logic [31:0] server_addr;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_addr;
        logic [31:0] lease_seconds;
        logic [3:0]  found_mask;
        logic        truncated;
    } out_item_t;

    // byte as classified by the front end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       is_op;
        logic       is_txn;
        logic       is_yiaddr;
        logic       header_end;
        logic       is_option;
        logic       short_dgram;
    } class_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] slot;
    } slot_t;

    function automatic slot_t slot_of(input logic [7:0] code);
        slot_t s;
        s.valid = 1'b1;
        s.slot  = SLOT_MASK;
        unique case (code)
            OPT_MASK:   s.slot = SLOT_MASK;
            OPT_ROUTER: s.slot = SLOT_ROUTER;
            OPT_SERVER: s.slot = SLOT_SERVER;
            OPT_LEASE:  s.slot = SLOT_LEASE;
            default:    s.valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dhcp_reply_option_parser_unit.sv
// flow: a pushed byte is classified and queued; the byte parser takes it from the queue
//   head and pushes a last byte's result into the result queue, from which it is popped
// throughput: one byte per cycle, stalled only while a last byte meets a full result queue
// reset: queues empty, byte counter and parse state cleared, expect_ack 0,
//   expected transaction id 0x12345678
`default_nettype none

module dhcp_reply_option_parser_unit
    import dhcp_rop_pkg::*;
#(
    parameter int MAX_DATAGRAM = 1024,
    parameter int QUEUE_DEPTH  = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_item_t    in_item,
    output logic             full,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        out_item,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    class_item_t cls_in;
    class_item_t cls_out;
    logic        cls_empty;
    logic        cls_pop;
    logic        res_full;
    logic        res_push;
    out_item_t   res_item;
    logic        in_accept;

    assign in_accept = push && !full;

    dhcp_rop_front #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_item (in_item),
        .cls     (cls_in)
    );

    dhcp_rop_fifo #(
        .WIDTH ($bits(class_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (cls_pop),
        .rdata (cls_out),
        .empty (cls_empty)
    );

    dhcp_rop_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cls_valid (!cls_empty),
        .cls       (cls_out),
        .res_full  (res_full),
        .cls_pop   (cls_pop),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    dhcp_rop_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_item),
        .empty (empty)
    );

endmodule

`default_nettype wire

FILE: rtl/dhcp_rop_fifo.sv
`default_nettype none

module dhcp_rop_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dhcp_rop_front.sv
`default_nettype none

module dhcp_rop_front
    import dhcp_rop_pkg::*;
#(
    parameter int MAX_DATAGRAM = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire in_item_t    in_item,
    output class_item_t      cls
);

    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dropped;

    assign dropped = (pos_reg >= POS_W'(MAX_DATAGRAM));

    always_comb
    begin
        cls.data_byte   = in_item.data_byte;
        cls.last_byte   = in_item.last_byte;
        cls.is_op       = !dropped && (pos_reg == '0);
        cls.is_txn      = !dropped && (pos_reg >= POS_W'(4)) && (pos_reg <= POS_W'(7));
        cls.is_yiaddr   = !dropped && (pos_reg >= POS_W'(16)) && (pos_reg <= POS_W'(19));
        cls.header_end  = !dropped && (pos_reg == POS_W'(HEADER_BYTES - 1));
        cls.is_option   = !dropped && (pos_reg >= POS_W'(HEADER_BYTES));
        // fewer than a full header once this byte is counted
        cls.short_dgram = (pos_reg < POS_W'(HEADER_BYTES - 1));
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (in_item.last_byte)
            begin
                pos_next = '0;
            end
            else if (!dropped)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dhcp_rop_back.sv
`default_nettype none

module dhcp_rop_back
    import dhcp_rop_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        cls_valid,
    input  wire class_item_t cls,
    input  wire logic        res_full,
    output logic             cls_pop,
    output logic             res_push,
    output out_item_t        res_item
);

    logic        expect_ack_reg;
    logic [31:0] expected_txn_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  remain_reg, remain_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic        op_ok_reg, op_ok_next;
    logic [31:0] txn_reg, txn_next;
    logic [31:0] yiaddr_reg, yiaddr_next;
    logic [31:0] capt_reg [4];
    logic [31:0] capt_next [4];
    logic [3:0]  seen_reg, seen_next;
    logic        rejected_reg, rejected_next;
    logic        acked_reg, acked_next;

    logic        go;
    logic        accepted;
    logic        offer_acc;
    logic [1:0]  status;
    slot_t       slot;
    logic [7:0]  d;

    assign go       = cls_valid && (!cls.last_byte || !res_full);
    assign cls_pop  = go;
    assign res_push = go && cls.last_byte;
    assign d        = cls.data_byte;
    assign slot     = slot_of(code_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        code_next     = code_reg;
        remain_next   = remain_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        op_ok_next    = op_ok_reg;
        txn_next      = txn_reg;
        yiaddr_next   = yiaddr_reg;
        capt_next     = capt_reg;
        seen_next     = seen_reg;
        rejected_next = rejected_reg;
        acked_next    = acked_reg;

        if (cls.is_op)
        begin
            op_ok_next = (d == OP_REPLY);
        end
        if (cls.is_txn)
        begin
            txn_next = {txn_reg[23:0], d};
        end
        if (cls.is_yiaddr)
        begin
            yiaddr_next = {yiaddr_reg[23:0], d};
        end
        if (cls.header_end)
        begin
            phase_next = PH_CODE;
        end

        if (cls.is_option)
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    if (d == OPT_END)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (d != OPT_PAD)
                    begin
                        code_next  = d;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    remain_next = d;
                    shift_next  = '0;
                    count_next  = '0;
                    if (d == 8'd0)
                    begin
                        phase_next = PH_CODE;
                        if (code_reg == OPT_TYPE && !expect_ack_reg)
                        begin
                            rejected_next = 1'b1;
                            phase_next    = PH_DONE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    // type option decides on its first value byte
                    if (code_reg == OPT_TYPE && count_reg == 3'd0 &&
                        !expect_ack_reg && d != MSG_OFFER)
                    begin
                        count_next    = 3'd1;
                        rejected_next = 1'b1;
                        phase_next    = PH_DONE;
                    end
                    else if (code_reg == OPT_TYPE && count_reg == 3'd0 &&
                             expect_ack_reg && d == MSG_ACK)
                    begin
                        count_next = 3'd1;
                        acked_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (code_reg == OPT_TYPE && count_reg == 3'd0)
                        begin
                            count_next = 3'd1;
                        end
                        else if (slot.valid && count_reg < 3'd4)
                        begin
                            shift_next = {shift_reg[23:0], d};
                            count_next = count_reg + 1'b1;
                            if (count_reg == 3'd3 && !expect_ack_reg)
                            begin
                                capt_next[slot.slot] = {shift_reg[23:0], d};
                                seen_next[slot.slot] = 1'b1;
                            end
                        end
                        remain_next = remain_reg - 1'b1;
                        if (remain_reg == 8'd1)
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (cls.short_dgram)
        begin
            status = ST_TOO_SHORT;
        end
        else if (!op_ok_next)
        begin
            status = ST_NOT_SERVER;
        end
        else if (!expect_ack_reg)
        begin
            status = rejected_next ? ST_BAD_TYPE : ST_ACCEPTED;
        end
        else
        begin
            status = acked_next ? ST_ACCEPTED : ST_BAD_TYPE;
        end
    end

    assign accepted  = (status == ST_ACCEPTED);
    assign offer_acc = accepted && !expect_ack_reg;

    always_comb
    begin
        res_item.status        = status;
        res_item.txn_match     = accepted && (txn_next == expected_txn_reg);
        res_item.txn_id        = accepted ? txn_next : '0;
        res_item.client_addr   = accepted ? yiaddr_next : '0;
        res_item.server_addr   = offer_acc ? capt_next[SLOT_SERVER] : '0;
        res_item.subnet_mask   = offer_acc ? capt_next[SLOT_MASK] : '0;
        res_item.gateway_addr  = offer_acc ? capt_next[SLOT_ROUTER] : '0;
        res_item.lease_seconds = offer_acc ? capt_next[SLOT_LEASE] : '0;
        res_item.found_mask    = offer_acc ? seen_next : '0;
        res_item.truncated     = (phase_next == PH_LEN) || (phase_next == PH_VALUE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_ack_reg   <= 1'b0;
            expected_txn_reg <= TXN_ID_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EXPECT_ACK: expect_ack_reg   <= cfg_wdata[0];
                REG_TXN_ID:     expected_txn_reg <= cfg_wdata;
                default:        expect_ack_reg   <= expect_ack_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            code_reg     <= '0;
            remain_reg   <= '0;
            shift_reg    <= '0;
            count_reg    <= '0;
            op_ok_reg    <= 1'b0;
            txn_reg      <= '0;
            yiaddr_reg   <= '0;
            capt_reg     <= '{default: '0};
            seen_reg     <= '0;
            rejected_reg <= 1'b0;
            acked_reg    <= 1'b0;
        end
        else if (go)
        begin
            if (cls.last_byte)
            begin
                // datagram done, start clean
                phase_reg    <= PH_HEADER;
                code_reg     <= '0;
                remain_reg   <= '0;
                shift_reg    <= '0;
                count_reg    <= '0;
                op_ok_reg    <= 1'b0;
                txn_reg      <= '0;
                yiaddr_reg   <= '0;
                capt_reg     <= '{default: '0};
                seen_reg     <= '0;
                rejected_reg <= 1'b0;
                acked_reg    <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                code_reg     <= code_next;
                remain_reg   <= remain_next;
                shift_reg    <= shift_next;
                count_reg    <= count_next;
                op_ok_reg    <= op_ok_next;
                txn_reg      <= txn_next;
                yiaddr_reg   <= yiaddr_next;
                capt_reg     <= capt_next;
                seen_reg     <= seen_next;
                rejected_reg <= rejected_next;
                acked_reg    <= acked_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import dhcp_rop_pkg::*;

    localparam int MAX_DGRAM   = 1024;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    in_item_t    in_item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   out_item;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    dhcp_reply_option_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // items waiting to be offered, and verdicts waiting to come out
    in_item_t  byte_q[$];
    out_item_t verdict_q[$];
    logic [7:0] dg[$];

    logic [7:0] capture_codes[4] = '{OPT_MASK, OPT_ROUTER, OPT_SERVER, OPT_LEASE};

    int mismatches = 0;
    int results_seen = 0;
    int bytes_queued = 0;
    int cycle_count = 0;
    bit no_gaps = 1'b0;
    bit burst_phase = 1'b0;

    // configuration as the block should hold it
    bit          mode_ack = 1'b0;
    logic [31:0] want_txn = TXN_ID_RESET;

    // parser state of the current datagram
    int          dg_pos = 0;
    logic [2:0]  phase = PH_HEADER;
    logic [7:0]  opt_code = '0;
    logic [7:0]  opt_left = '0;
    logic [31:0] val_shift = '0;
    int          val_cnt = 0;
    bit          op_good = 1'b0;
    logic [31:0] hdr_txn = '0;
    logic [31:0] hdr_yiaddr = '0;
    logic [31:0] caught[4] = '{default: '0};
    logic [3:0]  seen = '0;
    bit          rejected = 1'b0;
    bit          acked = 1'b0;

    function automatic void parse_byte(input in_item_t it);
        logic [7:0] d;
        int         slot;
        bit         decided;
        bit         accepted;
        bit         offer_ok;
        out_item_t  v;
        d = it.data_byte;
        if (dg_pos < MAX_DGRAM)
        begin
            if (dg_pos < HEADER_BYTES)
            begin
                if (dg_pos == 0)
                    op_good = (d == OP_REPLY);
                else if (dg_pos >= 4 && dg_pos <= 7)
                    hdr_txn = {hdr_txn[23:0], d};
                else if (dg_pos >= 16 && dg_pos <= 19)
                    hdr_yiaddr = {hdr_yiaddr[23:0], d};
                if (dg_pos == HEADER_BYTES - 1)
                    phase = PH_CODE;
            end
            else
            begin
                case (phase)
                    PH_CODE:
                    begin
                        if (d == OPT_END)
                            phase = PH_DONE;
                        else if (d != OPT_PAD)
                        begin
                            opt_code = d;
                            phase = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        opt_left = d;
                        val_shift = '0;
                        val_cnt = 0;
                        if (d == 8'd0)
                        begin
                            phase = PH_CODE;
                            // an empty type option is a reject only for offers
                            if (opt_code == OPT_TYPE && !mode_ack)
                            begin
                                rejected = 1'b1;
                                phase = PH_DONE;
                            end
                        end
                        else
                            phase = PH_VALUE;
                    end
                    PH_VALUE:
                    begin
                        decided = 1'b0;
                        if (opt_code == OPT_TYPE && val_cnt == 0)
                        begin
                            val_cnt = 1;
                            if (!mode_ack && d != MSG_OFFER)
                            begin
                                rejected = 1'b1;
                                decided = 1'b1;
                            end
                            else if (mode_ack && d == MSG_ACK)
                            begin
                                acked = 1'b1;
                                decided = 1'b1;
                            end
                        end
                        if (decided)
                            phase = PH_DONE;
                        else
                        begin
                            case (opt_code)
                                OPT_MASK:   slot = SLOT_MASK;
                                OPT_ROUTER: slot = SLOT_ROUTER;
                                OPT_SERVER: slot = SLOT_SERVER;
                                OPT_LEASE:  slot = SLOT_LEASE;
                                default:    slot = -1;
                            endcase
                            if (slot >= 0 && val_cnt < 4)
                            begin
                                val_shift = {val_shift[23:0], d};
                                val_cnt++;
                                if (val_cnt == 4 && !mode_ack)
                                begin
                                    caught[slot] = val_shift;
                                    seen[slot] = 1'b1;
                                end
                            end
                            opt_left = opt_left - 8'd1;
                            if (opt_left == 8'd0)
                                phase = PH_CODE;
                        end
                    end
                    default: ;
                endcase
            end
            dg_pos++;
        end

        if (it.last_byte)
        begin
            if (dg_pos < HEADER_BYTES)
                v.status = ST_TOO_SHORT;
            else if (!op_good)
                v.status = ST_NOT_SERVER;
            else if (!mode_ack)
                v.status = rejected ? ST_BAD_TYPE : ST_ACCEPTED;
            else
                v.status = acked ? ST_ACCEPTED : ST_BAD_TYPE;
            accepted = (v.status == ST_ACCEPTED);
            offer_ok = accepted && !mode_ack;
            v.txn_match     = accepted && (hdr_txn == want_txn);
            v.txn_id        = accepted ? hdr_txn : '0;
            v.client_addr   = accepted ? hdr_yiaddr : '0;
            v.server_addr   = offer_ok ? caught[SLOT_SERVER] : '0;
            v.subnet_mask   = offer_ok ? caught[SLOT_MASK] : '0;
            v.gateway_addr  = offer_ok ? caught[SLOT_ROUTER] : '0;
            v.lease_seconds = offer_ok ? caught[SLOT_LEASE] : '0;
            v.found_mask    = offer_ok ? seen : 4'd0;
            v.truncated     = (phase == PH_LEN || phase == PH_VALUE);
            verdict_q.push_back(v);

            dg_pos = 0;
            phase = PH_HEADER;
            opt_code = '0;
            opt_left = '0;
            val_shift = '0;
            val_cnt = 0;
            op_good = 1'b0;
            hdr_txn = '0;
            hdr_yiaddr = '0;
            caught = '{default: '0};
            seen = '0;
            rejected = 1'b0;
            acked = 1'b0;
        end
    endfunction

    task automatic check_verdict(input out_item_t got, input out_item_t want);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.txn_match !== want.txn_match)
        begin
            $error("txn_match: expected %0d, got %0d", want.txn_match, got.txn_match);
            mismatches++;
        end
        if (got.txn_id !== want.txn_id)
        begin
            $error("txn_id: expected %h, got %h", want.txn_id, got.txn_id);
            mismatches++;
        end
        if (got.client_addr !== want.client_addr)
        begin
            $error("client_addr: expected %h, got %h", want.client_addr, got.client_addr);
            mismatches++;
        end
        if (got.server_addr !== want.server_addr)
        begin
            $error("server_addr: expected %h, got %h", want.server_addr, got.server_addr);
            mismatches++;
        end
        if (got.subnet_mask !== want.subnet_mask)
        begin
            $error("subnet_mask: expected %h, got %h", want.subnet_mask, got.subnet_mask);
            mismatches++;
        end
        if (got.gateway_addr !== want.gateway_addr)
        begin
            $error("gateway_addr: expected %h, got %h", want.gateway_addr, got.gateway_addr);
            mismatches++;
        end
        if (got.lease_seconds !== want.lease_seconds)
        begin
            $error("lease_seconds: expected %h, got %h",
                   want.lease_seconds, got.lease_seconds);
            mismatches++;
        end
        if (got.found_mask !== want.found_mask)
        begin
            $error("found_mask: expected %b, got %b", want.found_mask, got.found_mask);
            mismatches++;
        end
        if (got.truncated !== want.truncated)
        begin
            $error("truncated: expected %0d, got %0d", want.truncated, got.truncated);
            mismatches++;
        end
    endtask

    // mostly back to back, some short pauses, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int tx_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                parse_byte(in_item);
                tx_gap = draw_gap();
            end
            if (push && full)
                ;   // hold the item until taken
            else if (tx_gap > 0)
            begin
                tx_gap--;
                push <= 1'b0;
            end
            else if (byte_q.size() > 0)
            begin
                push <= 1'b1;
                in_item <= byte_q.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    int rx_gap = 0;
    int rx_hold = 0;
    bit hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict with no datagram pending");
                    mismatches++;
                end
                else
                    check_verdict(out_item, verdict_q.pop_front());
                results_seen++;
                rx_gap = draw_gap();
            end
            // one long hold-off so the block backs up to its input
            if (burst_phase && !hold_done)
            begin
                rx_hold = 300;
                hold_done = 1'b1;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic void start_dg(input logic [7:0] op, input logic [31:0] txn,
                                     input logic [31:0] yiaddr);
        dg.delete();
        repeat (HEADER_BYTES) dg.push_back(8'($urandom));
        dg[0] = op;
        for (int i = 0; i < 4; i++)
        begin
            dg[4 + i] = txn[31 - 8 * i -: 8];
            dg[16 + i] = yiaddr[31 - 8 * i -: 8];
        end
    endfunction

    function automatic void add_opt(input logic [7:0] code, input int len,
                                    input logic [31:0] value);
        dg.push_back(code);
        dg.push_back(8'(len));
        for (int i = 0; i < len; i++)
            dg.push_back((i < 4) ? value[31 - 8 * i -: 8] : 8'($urandom));
    endfunction

    function automatic void send_dg(input bit close);
        in_item_t it;
        foreach (dg[i])
        begin
            it.data_byte = dg[i];
            it.last_byte = close && (i == dg.size() - 1);
            byte_q.push_back(it);
        end
        bytes_queued += dg.size();
    endfunction

    function automatic void random_datagram();
        int         kind;
        int         len;
        int         r;
        logic [7:0] msg;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            start_dg(($urandom_range(0, 9) == 0) ? 8'($urandom) : OP_REPLY,
                     $urandom_range(0, 1) ? want_txn : $urandom, $urandom);
            repeat ($urandom_range(0, 8))
            begin
                case ($urandom_range(0, 7))
                    0: dg.push_back(OPT_PAD);
                    1, 2, 3:
                    begin
                        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 4;
                        add_opt(capture_codes[$urandom_range(0, 3)], len, $urandom);
                    end
                    4, 5:
                    begin
                        r = $urandom_range(0, 5);
                        if (r < 4)
                            msg = mode_ack ? MSG_ACK : MSG_OFFER;
                        else if (r == 4)
                            msg = mode_ack ? MSG_OFFER : MSG_ACK;
                        else
                            msg = 8'($urandom);
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1;
                        add_opt(OPT_TYPE, len, {msg, 24'($urandom)});
                    end
                    default: add_opt(8'($urandom), $urandom_range(0, 12), $urandom);
                endcase
            end
            if ($urandom_range(0, 4) != 0)
                dg.push_back(OPT_END);
            repeat ($urandom_range(0, 4)) dg.push_back(8'($urandom));
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) void'(dg.pop_back());
        end
        else if (kind < 97)
        begin
            dg.delete();
            if (kind < 80)
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 239) : $urandom_range(1, 8);
            else
                len = $urandom_range(240, 400);
            repeat (len) dg.push_back(8'($urandom));
            if ($urandom_range(0, 1))
                dg[0] = OP_REPLY;
        end
        else
        begin
            start_dg(OP_REPLY, want_txn, $urandom);
            len = $urandom_range(MAX_DGRAM + 1, MAX_DGRAM + 76);
            while (dg.size() < len)
                dg.push_back(8'($urandom));
        end
        send_dg(1'b1);
    endfunction

    // sampled mid-cycle so the driver's updates at the edge are already visible
    task automatic wait_idle();
        while (byte_q.size() != 0 || push || verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_EXPECT_ACK)
            mode_ack = value[0];
        else
            want_txn = value;
    endtask

    initial
    begin
        logic [31:0] txn;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // offers under the reset configuration
        start_dg(OP_REPLY, TXN_ID_RESET, 32'hffff_ffff);
        dg.push_back(OPT_PAD);
        add_opt(OPT_TYPE, 1, {MSG_OFFER, 24'h0});
        add_opt(OPT_MASK, 4, 32'hffff_ff00);
        add_opt(OPT_ROUTER, 8, $urandom);
        add_opt(OPT_SERVER, 4, 32'h0);
        add_opt(OPT_LEASE, 4, 32'hffff_ffff);
        dg.push_back(OPT_END);
        send_dg(1'b1);
        // no type option, short mask ignored, long lease, server given twice
        start_dg(OP_REPLY, 32'h0, 32'h0);
        add_opt(OPT_MASK, 2, $urandom);
        add_opt(OPT_LEASE, 7, $urandom);
        add_opt(OPT_SERVER, 4, $urandom);
        add_opt(OPT_SERVER, 4, $urandom);
        dg.push_back(OPT_END);
        send_dg(1'b1);
        // op byte not a reply
        start_dg(8'd1, TXN_ID_RESET, $urandom);
        add_opt(OPT_TYPE, 1, {MSG_OFFER, 24'h0});
        send_dg(1'b1);
        start_dg(8'hff, TXN_ID_RESET, $urandom);
        send_dg(1'b1);
        // wrong type, later options ignored
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        add_opt(OPT_TYPE, 1, {MSG_ACK, 24'h0});
        add_opt(OPT_MASK, 4, $urandom);
        send_dg(1'b1);
        // empty type option
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        add_opt(OPT_MASK, 4, $urandom);
        add_opt(OPT_TYPE, 0, 32'h0);
        dg.push_back(OPT_END);
        send_dg(1'b1);
        // header and nothing else
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        send_dg(1'b1);
        // one byte short of a header, then a lone byte
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        void'(dg.pop_back());
        send_dg(1'b1);
        dg.delete();
        dg.push_back(OPT_END);
        send_dg(1'b1);
        // cut after an option code, after its length, inside its value
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        add_opt(OPT_TYPE, 1, {MSG_OFFER, 24'h0});
        dg.push_back(OPT_LEASE);
        send_dg(1'b1);
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        dg.push_back(OPT_LEASE);
        dg.push_back(8'd4);
        send_dg(1'b1);
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        add_opt(OPT_MASK, 4, $urandom);
        void'(dg.pop_back());
        send_dg(1'b1);
        // junk after the end option
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        add_opt(OPT_ROUTER, 4, $urandom);
        dg.push_back(OPT_END);
        add_opt(OPT_TYPE, 1, {MSG_ACK, 24'h0});
        send_dg(1'b1);
        // oversize: the value of a bad type option falls past the drop point
        start_dg(OP_REPLY, TXN_ID_RESET, $urandom);
        add_opt(OPT_SERVER, 4, $urandom);
        while (dg.size() < MAX_DGRAM - 2)
            dg.push_back(OPT_PAD);
        add_opt(OPT_TYPE, 1, {8'd7, 24'h0});
        repeat (40) dg.push_back(8'($urandom));
        send_dg(1'b1);
        wait_idle();

        write_reg(REG_EXPECT_ACK, 32'd1);
        write_reg(REG_TXN_ID, 32'hffff_ffff);
        start_dg(OP_REPLY, 32'hffff_ffff, $urandom);
        add_opt(OPT_MASK, 4, $urandom);
        add_opt(OPT_TYPE, 1, {MSG_ACK, 24'h0});
        send_dg(1'b1);
        start_dg(OP_REPLY, 32'hffff_ffff, $urandom);
        add_opt(OPT_TYPE, 1, {MSG_OFFER, 24'h0});
        dg.push_back(OPT_END);
        send_dg(1'b1);
        start_dg(OP_REPLY, $urandom, $urandom);
        add_opt(OPT_TYPE, 0, 32'h0);
        add_opt(OPT_TYPE, 3, {MSG_OFFER, 24'h0});
        add_opt(OPT_TYPE, 1, {MSG_ACK, 24'h0});
        send_dg(1'b1);
        start_dg(OP_REPLY, 32'hffff_ffff, $urandom);
        add_opt(OPT_LEASE, 4, $urandom);
        dg.push_back(OPT_END);
        send_dg(1'b1);
        start_dg(8'h00, 32'hffff_ffff, $urandom);
        add_opt(OPT_TYPE, 1, {MSG_ACK, 24'h0});
        send_dg(1'b1);
        wait_idle();

        // mode flips between the two halves of one datagram
        write_reg(REG_TXN_ID, 32'h0);
        start_dg(OP_REPLY, 32'h0, $urandom);
        add_opt(OPT_MASK, 4, $urandom);
        send_dg(1'b0);
        wait_idle();
        write_reg(REG_EXPECT_ACK, 32'd0);
        dg.delete();
        add_opt(OPT_TYPE, 1, {MSG_OFFER, 24'h0});
        add_opt(OPT_LEASE, 4, $urandom);
        dg.push_back(OPT_END);
        send_dg(1'b1);
        wait_idle();

        // tiny datagrams against a stalled receiver
        no_gaps = 1'b1;
        burst_phase = 1'b1;
        repeat (40)
        begin
            dg.delete();
            repeat ($urandom_range(1, 3)) dg.push_back(8'($urandom));
            send_dg(1'b1);
        end
        wait_idle();
        burst_phase = 1'b0;

        bytes_queued = 0;
        while (bytes_queued < 1600)
        begin
            write_reg(REG_EXPECT_ACK, 32'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: txn = 32'h0;
                1: txn = 32'hffff_ffff;
                default: txn = $urandom;
            endcase
            write_reg(REG_TXN_ID, txn);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (8) random_datagram();
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
